[rtl/crc32c_stream_assert.svh]
// Assertion macros for the RTL that checks itself.
`ifndef CRC32C_STREAM_ASSERT_SVH
`define CRC32C_STREAM_ASSERT_SVH

// Same-cycle implication, skipped while reset is high.
`define CRCS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, skipped while reset is high.
`define CRCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/crcs_pkg.sv]
package crcs_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned LaneCount  = 8;
   localparam int unsigned CrcWidth   = 32;
   localparam int unsigned CountWidth = 4;
   localparam int unsigned DataWidth  = LaneCount * ByteWidth;

   localparam logic [CrcWidth-1:0] CrcPoly = 32'h82F6_3B78;
   localparam logic [CrcWidth-1:0] CrcOnes = 32'hFFFF_FFFF;

   typedef logic [ByteWidth-1:0]                 byte_type;
   typedef logic [CountWidth-1:0]                count_type;
   typedef logic [DataWidth-1:0]                 data_type;
   typedef logic [CrcWidth-1:0]                  crc_type;
   // Row r holds the input bits that feed output bit r.
   typedef logic [CrcWidth-1:0][CrcWidth-1:0]    crc_mat_type;
   typedef logic [LaneCount-1:0][CrcWidth-1:0]   crc_lanes_type;

   // Shift a reflected CRC through the given number of zero data bits.
   function automatic crc_type crc_shift(crc_type v, int unsigned steps);
      crc_type r;
      r = v;
      for (int unsigned s = 0; s < steps; s++) begin
         r = {1'b0, r[CrcWidth-1:1]} ^ (r[0] ? CrcPoly : '0);
      end
      return r;
   endfunction

   // Row form of the zero-bit advance; evaluated on constants only.
   function automatic crc_mat_type adv_rows(int unsigned steps);
      crc_type     col;
      crc_mat_type rows;
      rows = '0;
      for (int j = 0; j < CrcWidth; j++) begin
         col = crc_shift(crc_type'(1) << j, steps);
         for (int r = 0; r < CrcWidth; r++) begin
            rows[r][j] = col[r];
         end
      end
      return rows;
   endfunction

   // GF(2) matrix times vector: each output bit is an independent parity.
   function automatic crc_type mat_apply(crc_mat_type rows, crc_type v);
      crc_type res;
      for (int r = 0; r < CrcWidth; r++) begin
         res[r] = ^(rows[r] & v);
      end
      return res;
   endfunction

endpackage

[rtl/crc32c_stream.sv]
// CRC-32C (Castagnoli, reflected polynomial 0x82F63B78) over a stream of
// 64-bit words. Each request transaction carries up to eight message bytes,
// lowest byte first; req_byte_count gives the number of valid low bytes
// (values above eight count as eight, bytes above the count are ignored).
// The running CRC starts at all ones. The transaction marked last closes the
// message: one response transaction carries the CRC XORed with all ones, and
// the running CRC reloads all ones for the next message. A last word with no
// bytes closes the message as it stands, so an empty message gives zero.
// Throughput is one word per clock while req_stall is low; a last word
// reaches rsp_valid through the stage 1, stage 2 and response registers.
// The rate is set by the running-CRC register loop, which advances the
// state by the word's byte count through one of nine constant XOR matrices.
// The byte lanes and the merge tree in front of it are pipelined. A response
// that waits under rsp_stall holds the pipeline and raises req_stall only
// while a second closing word sits in stage two and would overwrite it.
`include "crc32c_stream_assert.svh"

module crc32c_stream (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  crcs_pkg::data_type         req_data_word,
   input  crcs_pkg::count_type        req_byte_count,
   input  logic                       req_last_item,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output crcs_pkg::crc_type          rsp_crc_value
);
   import crcs_pkg::*;

   // Response register occupied and not taken this cycle.
   logic          rsp_busy;
   // Pipeline advances unless a closing word would overwrite a held response.
   logic          advance;

   count_type     count_sat;
   count_type     shift_bytes;
   data_type      aligned_word;
   crc_lanes_type lane_crc_in;

   // Stage 1: per-lane byte CRCs.
   logic          s1_valid_ff;
   crc_lanes_type s1_lane_ff;
   count_type     s1_count_ff;
   logic          s1_last_ff;

   // Stage 2: merged data contribution of the word.
   crc_type       merge_crc_in;
   logic          s2_valid_ff;
   crc_type       s2_data_ff;
   count_type     s2_count_ff;
   logic          s2_last_ff;

   // Running CRC and response register.
   crc_type       state_adv [LaneCount+1];
   crc_type       crc_in;
   crc_type       crc_ff;
   logic          rsp_valid_ff;
   crc_type       rsp_crc_ff;

   assign rsp_busy  = rsp_valid_ff && rsp_stall;
   assign advance   = !(rsp_busy && s2_valid_ff && s2_last_ff);
   assign req_stall = !advance;

   // Clamp the byte count to a full word.
   assign count_sat = (req_byte_count > CountWidth'(LaneCount)) ?
                      CountWidth'(LaneCount) : req_byte_count;

   // Push the valid bytes to the top of the word. Leading zero bytes leave a
   // zero CRC unchanged, so every lane position keeps a fixed advance.
   assign shift_bytes  = CountWidth'(LaneCount) - count_sat;
   assign aligned_word = req_data_word << {shift_bytes, 3'b000};

   for (genvar i = 0; i < LaneCount; i++) begin : g_lane
      crcs_lane u_lane (
         .data_byte (aligned_word[ByteWidth*i +: ByteWidth]),
         .lane_crc  (lane_crc_in[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_lane_ff  <= lane_crc_in;
         s1_count_ff <= count_sat;
         s1_last_ff  <= req_last_item;
      end
   end

   // Combine the lanes into the word's contribution from a zero state.
   crcs_merge u_merge (
      .lane_crc (s1_lane_ff),
      .data_crc (merge_crc_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_data_ff  <= merge_crc_in;
         s2_count_ff <= s1_count_ff;
         s2_last_ff  <= s1_last_ff;
      end
   end

   // Advance the running CRC past k zero bytes, one matrix per byte count.
   for (genvar k = 0; k <= LaneCount; k++) begin : g_state
      localparam crc_mat_type Rows = adv_rows(ByteWidth * k);
      assign state_adv[k] = mat_apply(Rows, crc_ff);
   end

   // CRC is linear: state part and data part add in GF(2).
   assign crc_in = state_adv[s2_count_ff] ^ s2_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CrcOnes;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Hold a waiting response; otherwise load the next closing word.
         if (!rsp_busy) begin
            rsp_valid_ff <= s2_valid_ff && s2_last_ff;
         end
         if (advance && s2_valid_ff) begin
            // Reload all ones once the message closes.
            crc_ff <= s2_last_ff ? CrcOnes : crc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s2_valid_ff && s2_last_ff) begin
         rsp_crc_ff <= ~crc_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_crc_value = rsp_crc_ff;

   // A closing word leaves the running CRC at all ones.
   `CRCS_ASSERT_NEXT(a_reload_after_last, clock, reset,
      advance && s2_valid_ff && s2_last_ff, crc_ff == CrcOnes,
      "running CRC not reloaded after a last word")

   // A held pipeline must not move the running CRC.
   `CRCS_ASSERT_NEXT(a_hold_on_stall, clock, reset,
      !advance, $stable(crc_ff) && $stable(s2_data_ff),
      "running CRC moved while the pipeline was held")

   // An empty non-last word leaves the running CRC unchanged.
   `CRCS_ASSERT_NEXT(a_empty_word_keeps_crc, clock, reset,
      advance && s2_valid_ff && !s2_last_ff && (s2_count_ff == '0),
      crc_ff == $past(crc_ff),
      "empty word changed the running CRC")

endmodule

[rtl/crcs_lane.sv]
module crcs_lane (
   input  crcs_pkg::byte_type data_byte,
   output crcs_pkg::crc_type  lane_crc
);
   import crcs_pkg::*;

   crc_type fold_crc;

   // Fold one byte into a zero CRC, LSB first.
   always_comb begin
      fold_crc = crc_type'(data_byte);
      for (int b = 0; b < ByteWidth; b++) begin
         fold_crc = {1'b0, fold_crc[CrcWidth-1:1]} ^ (fold_crc[0] ? CrcPoly : '0);
      end
   end

   assign lane_crc = fold_crc;

endmodule

[rtl/crcs_merge.sv]
module crcs_merge (
   input  crcs_pkg::crc_lanes_type lane_crc,
   output crcs_pkg::crc_type       data_crc
);
   import crcs_pkg::*;

   crc_lanes_type adv_part;
   crc_type       sum_crc;

   // Advance each lane past the bytes that follow it in the word.
   for (genvar i = 0; i < LaneCount; i++) begin : g_adv
      localparam crc_mat_type Rows = adv_rows(ByteWidth * (LaneCount - 1 - i));
      assign adv_part[i] = mat_apply(Rows, lane_crc[i]);
   end

   always_comb begin
      sum_crc = '0;
      for (int i = 0; i < LaneCount; i++) begin
         sum_crc = sum_crc ^ adv_part[i];
      end
   end

   assign data_crc = sum_crc;

endmodule
